### design/assert_macros.svh
// Assertion macros shared by the kinematics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### design/tjfk_pkg.sv
// Package: types, constants and tables for the three-joint kinematics pipeline.
package tjfk_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS = 16;
    localparam int TABLE_LEN = 24;
    localparam int CW = 34;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd2;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
    localparam logic [31:0] ANG_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int MATH_LAT = 5;
    localparam int TOTAL_LAT = CORDIC_LAT + MATH_LAT;
    localparam logic signed [63:0] POS_MAX = 64'sd524287;
    localparam logic signed [63:0] POS_MIN = -64'sd524288;

    typedef struct packed {
        logic signed [15:0] base_angle;
        logic signed [15:0] shoulder_angle;
        logic signed [15:0] elbow_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic saturated;
    } out_item_t;

    typedef struct packed {
        logic [15:0] link_offset;
        logic [15:0] link_length;
        logic [15:0] base_height;
    } cfg_t;

    typedef struct packed {
        logic signed [17:0] s;
        logic signed [17:0] c;
    } sc_t;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;   1: t = 32'd316933406;
            2: t = 32'd167458907;   3: t = 32'd85004756;
            4: t = 32'd42667331;    5: t = 32'd21354465;
            6: t = 32'd10679838;    7: t = 32'd5340245;
            8: t = 32'd2670163;     9: t = 32'd1335087;
            10: t = 32'd667544;     11: t = 32'd333772;
            12: t = 32'd166886;     13: t = 32'd83443;
            14: t = 32'd41722;      15: t = 32'd20861;
            16: t = 32'd10430;      17: t = 32'd5215;
            18: t = 32'd2608;       19: t = 32'd1304;
            20: t = 32'd652;        21: t = 32'd326;
            22: t = 32'd163;        default: t = 32'd81;
        endcase
        return (t + ANG_HALF) & ANG_MASK;
    endfunction
endpackage

### design/tjfk_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of one angle.
module tjfk_cordic (
    input  logic clk,
    input  logic en,
    input  logic [15:0] angle,
    output tjfk_pkg::sc_t sc
);
    import tjfk_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic [31:0] z_reg [CORDIC_STAGES+1];
    logic flip_reg [CORDIC_STAGES+1];
    logic [31:0] z_in;
    logic signed [CW-1:0] x_fin, y_fin;
    logic signed [CW-1:0] x_rnd, y_rnd;
    sc_t sc_reg;

    assign z_in = {angle, 16'd0} & ANG_MASK;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg[0] <= z_in[31] ^ z_in[30];
            z_reg[0] <= (z_in[31] ^ z_in[30]) ? z_in + 32'h8000_0000 : z_in;
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic [31:0] A = atan_turns(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][31])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - A;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + A;
                end
            end
        end
    end

    assign x_fin = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    assign y_fin = flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
    assign x_rnd = (x_fin + CW'(8192)) >>> 14;
    assign y_rnd = (y_fin + CW'(8192)) >>> 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg.c <= x_rnd[17:0];
            sc_reg.s <= y_rnd[17:0];
        end
    end

    assign sc = sc_reg;
endmodule

### design/tjfk_math.sv
// Polynomial, projection, rounding and saturation stages of the kinematics.
module tjfk_math (
    input  logic clk,
    input  logic en,
    input  tjfk_pkg::cfg_t cfg,
    input  tjfk_pkg::sc_t sc1,
    input  tjfk_pkg::sc_t sc2,
    input  tjfk_pkg::sc_t sc3,
    output tjfk_pkg::out_item_t res
);
    import tjfk_pkg::*;

    // stage 1: products of B with sines and cosines, u
    logic signed [35:0] bs2_reg, bc2_reg, bs3_reg;
    logic signed [17:0] s1_1_reg, c1_1_reg, s2_1_reg, c2_1_reg, c3_1_reg;
    logic signed [16:0] a1_reg, h1_reg;
    // stage 2: 32-bit-fraction terms
    logic signed [63:0] t_bs2c3_reg, t_c2u_reg, t_bc2_reg;
    logic signed [63:0] t_bc2c3_reg, t_s2u_reg, t_rest_reg;
    logic signed [17:0] s1_2_reg, c1_2_reg;
    // stage 3: sums and x2 rounding
    logic signed [39:0] x2r_reg;
    logic signed [63:0] z_reg;
    logic signed [17:0] s1_3_reg, c1_3_reg;
    // stage 4: projection
    logic signed [63:0] px_reg, py_reg, pz_reg;
    out_item_t res_reg;

    logic signed [63:0] x2, zs;
    logic signed [63:0] pxr, pyr, pzr;
    logic sx, sy, sz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bs2_reg <= 36'(signed'({1'b0, cfg.link_length})) * 36'(sc2.s);
            bc2_reg <= 36'(signed'({1'b0, cfg.link_length})) * 36'(sc2.c);
            bs3_reg <= 36'(signed'({1'b0, cfg.link_length})) * 36'(sc3.s);
            s1_1_reg <= sc1.s;
            c1_1_reg <= sc1.c;
            s2_1_reg <= sc2.s;
            c2_1_reg <= sc2.c;
            c3_1_reg <= sc3.c;
            a1_reg <= signed'({1'b0, cfg.link_offset});
            h1_reg <= signed'({1'b0, cfg.base_height});
        end
    end

    logic signed [40:0] u1;
    assign u1 = (41'(a1_reg) <<< 16) + 41'(bs3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_bs2c3_reg <= 64'(bs2_reg) * 64'(c3_1_reg);
            t_c2u_reg <= 64'(c2_1_reg) * 64'(u1);
            t_bc2_reg <= 64'(bc2_reg) <<< 16;
            t_bc2c3_reg <= 64'(bc2_reg) * 64'(c3_1_reg);
            t_s2u_reg <= 64'(s2_1_reg) * 64'(u1);
            t_rest_reg <= ((64'(a1_reg) + 64'(h1_reg)) <<< 32) + (64'(bs2_reg) <<< 16);
            s1_2_reg <= s1_1_reg;
            c1_2_reg <= c1_1_reg;
        end
    end

    assign x2 = t_bs2c3_reg + t_c2u_reg + t_bc2_reg;
    assign zs = t_s2u_reg - t_bc2c3_reg + t_rest_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2r_reg <= 40'((x2 + 64'sd32768) >>> 16);
            z_reg <= zs;
            s1_3_reg <= s1_2_reg;
            c1_3_reg <= c1_2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 64'(c1_3_reg) * 64'(x2r_reg);
            py_reg <= 64'(s1_3_reg) * 64'(x2r_reg);
            pz_reg <= z_reg;
        end
    end

    assign pxr = (px_reg + 64'sh8000_0000) >>> 32;
    assign pyr = (py_reg + 64'sh8000_0000) >>> 32;
    assign pzr = (pz_reg + 64'sh8000_0000) >>> 32;
    assign sx = (pxr > POS_MAX) || (pxr < POS_MIN);
    assign sy = (pyr > POS_MAX) || (pyr < POS_MIN);
    assign sz = (pzr > POS_MAX) || (pzr < POS_MIN);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.pos_x <= (pxr > POS_MAX) ? 20'sh7FFFF : (pxr < POS_MIN) ? 20'sh80000
                : pxr[19:0];
            res_reg.pos_y <= (pyr > POS_MAX) ? 20'sh7FFFF : (pyr < POS_MIN) ? 20'sh80000
                : pyr[19:0];
            res_reg.pos_z <= (pzr > POS_MAX) ? 20'sh7FFFF : (pzr < POS_MIN) ? 20'sh80000
                : pzr[19:0];
            res_reg.saturated <= sx | sy | sz;
        end
    end

    assign res = res_reg;
endmodule

### design/tjfk_skid.sv
// Output skid buffer parting the pipeline from the receiver.
`include "assert_macros.svh"
module tjfk_skid (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  tjfk_pkg::out_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output tjfk_pkg::out_item_t out_data
);
    import tjfk_pkg::*;

    logic full_reg, full_next;
    out_item_t buf_reg;

    assign in_ready = !full_reg;
    assign out_valid = full_reg || in_valid;
    assign out_data = full_reg ? buf_reg : in_data;
    assign full_next = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (!full_reg)
            buf_reg <= in_data;
    end

    `ASSERT_IMPL(a_hold, clk, rst_n, (full_reg && !out_ready) |=> full_reg, "skid item lost")
    `ASSERT_NEVER(a_drop, clk, rst_n, full_reg && in_valid && in_ready, "skid overrun")
    `ASSERT_IMPL(a_keep, clk, rst_n, (full_reg && !out_ready) |=> $stable(buf_reg),
        "skid data changed")
endmodule

### design/three_joint_forward_kinematics_top.sv
// Top level of the three-joint forward kinematics pipeline.
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one joint-angle item:
//   base, shoulder and elbow angles, 32768 = 180 degrees.
//   Output channel (out_valid/out_ready/out_data) carries the end-effector
//   position in signed Q12.8 with a saturation flag.
//   Config port (cfg_we/cfg_index/cfg_data) sets link offset, link length
//   and base height; write only while idle.
// Timing:
//   The path is one fold stage and 16 CORDIC stages, a rounding register,
//   then five multiply/add/round stages.
//   Throughput is one item per cycle while the output is not stalled; the
//   CORDIC and multiplier pipeline then takes a new item every clock.
// Reset:
//   Clears all valid bits and loads the default geometry registers.
// Stall:
//   When the receiver stalls, the whole pipeline holds once the skid buffer
//   is full and the last stage holds an item; no item is lost or repeated.
`include "assert_macros.svh"
module three_joint_forward_kinematics_top (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  tjfk_pkg::in_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output tjfk_pkg::out_item_t out_data,
    input  logic cfg_we,
    input  logic [tjfk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import tjfk_pkg::*;

    cfg_t cfg_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic en, skid_ready;
    sc_t sc1, sc2, sc3;
    out_item_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_offset <= 16'd2432;
            cfg_reg.link_length <= 16'd2432;
            cfg_reg.base_height <= 16'd1946;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINK_OFFSET: cfg_reg.link_offset <= cfg_data;
                REG_LINK_LENGTH: cfg_reg.link_length <= cfg_data;
                REG_BASE_HEIGHT: cfg_reg.base_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance unless the last stage holds an item the skid cannot take
    assign en = skid_ready || !vld_reg[TOTAL_LAT-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
    end

    tjfk_cordic u_c1 (.clk(clk), .en(en), .angle(in_data.base_angle), .sc(sc1));
    tjfk_cordic u_c2 (.clk(clk), .en(en), .angle(in_data.shoulder_angle), .sc(sc2));
    tjfk_cordic u_c3 (.clk(clk), .en(en), .angle(in_data.elbow_angle), .sc(sc3));

    tjfk_math u_math (
        .clk(clk), .en(en), .cfg(cfg_reg),
        .sc1(sc1), .sc2(sc2), .sc3(sc3), .res(res)
    );

    tjfk_skid u_skid (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld_reg[TOTAL_LAT-1]), .in_ready(skid_ready), .in_data(res),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    `ASSERT_IMPL(a_stall, clk, rst_n, (!en) |=> $stable(vld_reg), "pipeline moved on stall")
    `ASSERT_IMPL(a_enter, clk, rst_n, (in_valid && en) |=> vld_reg[0], "item not entered")
    `ASSERT_NEVER(a_lose, clk, rst_n, vld_reg[TOTAL_LAT-1] && !skid_ready && en,
        "item dropped at output")
endmodule
